### rtl/assert_macros.svh
// Assertion macros shared by the RTL; they compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every clock edge outside reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/pfd_pkg.sv
// Types, constants and key-square functions for the Playfair digraph encryptor.
package pfd_pkg;

  localparam int SIDE      = 5;
  localparam int LETTER_W  = 5;
  localparam int ROW_W     = SIDE * LETTER_W;
  localparam int COORD_W   = 3;
  localparam int CFG_IDX_W = 3;

  typedef logic [LETTER_W-1:0]         letter_t;
  typedef logic [COORD_W-1:0]          coord_t;
  typedef logic [ROW_W-1:0]            row_t;
  typedef logic [SIDE-1:0][ROW_W-1:0]  square_t;
  typedef logic [CFG_IDX_W-1:0]        cfg_idx_t;

  localparam letter_t LETTER_A = 5'd0;
  localparam letter_t LETTER_I = 5'd8;
  localparam letter_t LETTER_J = 5'd9;
  localparam letter_t LETTER_Z = 5'd25;

  localparam cfg_idx_t REG_SQUARE_ROW_0 = 3'd0;
  localparam cfg_idx_t REG_SQUARE_ROW_4 = 3'd4;

  // alphabet without J, row 0 in the low slot
  localparam square_t SQUARE_RESET = {25'd27025109, 25'd21613104, 25'd16201099,
                                      25'd10755269, 25'd4294688};

  typedef struct packed {
    coord_t row;
    coord_t col;
  } pos_t;

  typedef struct packed {
    letter_t a;
    letter_t b;
  } pair_t;

  typedef struct packed {
    letter_t ans;
    letter_t next;
  } filler_t;

  function automatic letter_t fold_letter(letter_t l);
    letter_t v;
    v = (l > LETTER_Z) ? LETTER_Z : l;
    if (v == LETTER_J) v = LETTER_I;
    return v;
  endfunction

  function automatic letter_t letter_step(letter_t l);
    return (l == LETTER_Z) ? LETTER_A : l + 5'd1;
  endfunction

  // filler counter: skip the paired letter, never hand out J
  function automatic filler_t take_filler(letter_t f_in, letter_t l);
    letter_t f;
    filler_t t;
    f = f_in;
    if (l == f) f = letter_step(f);
    if (f == LETTER_J) f = f + 5'd1;
    t.ans = f;
    f = letter_step(f);
    if (f == LETTER_J) f = f + 5'd1;
    t.next = f;
    return t;
  endfunction

  function automatic coord_t coord_wrap(coord_t c);
    return (c == coord_t'(SIDE - 1)) ? '0 : c + 3'd1;
  endfunction

  function automatic letter_t cell_at(square_t sq, coord_t r, coord_t c);
    letter_t v;
    v = sq[r][c*LETTER_W +: LETTER_W];
    return v;
  endfunction

  // first match in row-major order wins; no match sits at row 0, col 0
  function automatic pos_t locate(square_t sq, letter_t l);
    pos_t p;
    p = '0;
    for (int r = SIDE - 1; r >= 0; r--) begin
      for (int c = SIDE - 1; c >= 0; c--) begin
        if (sq[r][c*LETTER_W +: LETTER_W] == l) begin
          p.row = coord_t'(r);
          p.col = coord_t'(c);
        end
      end
    end
    return p;
  endfunction

  function automatic pair_t encipher(square_t sq, letter_t a, letter_t b);
    pos_t  pa;
    pos_t  pb;
    pair_t e;
    pa = locate(sq, a);
    pb = locate(sq, b);
    if (pa.row == pb.row) begin
      e.a = cell_at(sq, pa.row, coord_wrap(pa.col));
      e.b = cell_at(sq, pb.row, coord_wrap(pb.col));
    end else if (pa.col == pb.col) begin
      e.a = cell_at(sq, coord_wrap(pa.row), pa.col);
      e.b = cell_at(sq, coord_wrap(pb.row), pb.col);
    end else begin
      e.a = cell_at(sq, pa.row, pb.col);
      e.b = cell_at(sq, pb.row, pa.col);
    end
    return e;
  endfunction

endpackage

### rtl/playfair_digraph_encryptor.sv
// Playfair digraph encryptor: letter pairing, filler counter and key-square lookup.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------
//   in      | in        | in_valid / in_stall  | plain_letter, message_end
//   out     | out       | out_valid / out_stall| cipher_letter, run_last
//   cfg     | in        | cfg_wr_en            | cfg_index, cfg_data
//
// An accepted letter updates the pairing state at once and, when it closes
// a digraph, loads one or two plaintext pairs into the pair register.
// The pair register feeds one cipher letter per cycle into the output
// register while the output does not stall, one letter per result beat;
// a letter that is only held gives no beat.
// The next letter is taken in the cycle the last letter of the loaded pairs leaves.
// Synchronous reset clears pairing state and valids and reloads the key square.
// Stall on the output freezes the output register and a loaded pair register.
`include "assert_macros.svh"

module playfair_digraph_encryptor (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  pfd_pkg::letter_t          plain_letter,
  input  logic                      message_end,
  output logic                      out_valid,
  input  logic                      out_stall,
  output pfd_pkg::letter_t          cipher_letter,
  output logic                      run_last,
  input  logic                      cfg_wr_en,
  input  pfd_pkg::cfg_idx_t         cfg_index,
  input  logic [pfd_pkg::ROW_W-1:0] cfg_data
);
  import pfd_pkg::*;

  square_t square;

  logic    held_valid, held_valid_next;
  letter_t held_letter, held_letter_next;
  letter_t filler_next, filler_next_next;

  // pair register: up to two plaintext pairs waiting for the cipher
  logic        pv;
  logic        two_pairs;
  logic [1:0]  idx;
  pair_t       pair0, pair1;

  logic        in_acc;
  logic        out_free, adv, cur_last, fin;
  pair_t       cur_pair, cur_enc;
  letter_t     cur_letter;

  letter_t     l;
  filler_t     t1, t2;
  logic        load_pairs, load_two;
  pair_t       pair0_next, pair1_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      square <= SQUARE_RESET;
    end else if (cfg_wr_en && cfg_index <= REG_SQUARE_ROW_4) begin
      square[cfg_index] <= cfg_data;
    end
  end

  // pairing and filler logic for the incoming letter
  always_comb begin
    l                = fold_letter(plain_letter);
    held_valid_next  = held_valid;
    held_letter_next = held_letter;
    filler_next_next = filler_next;
    load_pairs       = 1'b0;
    load_two         = 1'b0;
    pair0_next       = '0;
    pair1_next       = '0;
    t1               = take_filler(filler_next, held_valid ? held_letter : l);
    t2               = take_filler(t1.next, l);
    if (!held_valid) begin
      if (message_end) begin
        load_pairs       = 1'b1;
        pair0_next       = '{a: l, b: t1.ans};
        filler_next_next = t1.next;
      end else begin
        held_valid_next  = 1'b1;
        held_letter_next = l;
      end
    end else if (held_letter != l) begin
      load_pairs      = 1'b1;
      pair0_next      = '{a: held_letter, b: l};
      held_valid_next = 1'b0;
    end else begin
      // doubled letter: pair the first with a filler, keep the second (at message end, pair it with a filler too)
      load_pairs       = 1'b1;
      pair0_next       = '{a: held_letter, b: t1.ans};
      held_letter_next = l;
      filler_next_next = t1.next;
      if (message_end) begin
        load_two         = 1'b1;
        pair1_next       = '{a: l, b: t2.ans};
        filler_next_next = t2.next;
      end
    end
    if (message_end) begin
      filler_next_next = LETTER_A;
      held_valid_next  = 1'b0;
    end
  end

  always_comb begin
    out_free   = !out_valid || !out_stall;
    adv        = pv && out_free;
    cur_last   = idx[0] && (idx[1] || !two_pairs);
    fin        = adv && cur_last;
    in_stall   = pv && !fin;
    in_acc     = in_valid && !in_stall;
    cur_pair   = idx[1] ? pair1 : pair0;
    cur_enc    = encipher(square, cur_pair.a, cur_pair.b);
    cur_letter = idx[0] ? cur_enc.b : cur_enc.a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid  <= 1'b0;
      held_letter <= LETTER_A;
      filler_next <= LETTER_A;
    end else if (in_acc) begin
      held_valid  <= held_valid_next;
      held_letter <= held_letter_next;
      filler_next <= filler_next_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv        <= 1'b0;
      idx       <= 2'd0;
      two_pairs <= 1'b0;
    end else if (in_acc && load_pairs) begin
      pv        <= 1'b1;
      idx       <= 2'd0;
      two_pairs <= load_two;
    end else if (fin) begin
      pv <= 1'b0;
    end else if (adv) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && load_pairs) begin
      pair0 <= pair0_next;
      pair1 <= pair1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cipher_letter <= cur_letter;
      run_last      <= cur_last;
    end
  end

  `ASSERT_NEXT(a_pair_holds, clk, rst, pv && !adv, pv && idx == $past(idx))
  `ASSERT_NEXT(a_end_drops_held, clk, rst, in_acc && message_end, !held_valid)
  `ASSERT_SAME(a_filler_legal, clk, rst, 1'b1, filler_next != LETTER_J && filler_next <= LETTER_Z)
  `ASSERT_NEXT(a_adv_shows_beat, clk, rst, adv, out_valid)

endmodule
